/* hdl/pcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and helpers of the palette color cycler.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int unsigned MAX_CYCLES_DEF      = 6;
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	localparam int unsigned COLOR_W    = 32;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned MASK_W     = 6;
	localparam int unsigned DELAY_W    = 16;
	localparam int unsigned CYC_W      = 3;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned REG_DATA_W = 33;

	localparam logic [REG_IDX_W-1:0] REG_CYCLES_IN_USE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CYCLE_0       = 3'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK    = 2'd0,
		MODE_WRITE   = 2'd1,
		MODE_READ    = 2'd2,
		MODE_RESTORE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_RS_RD,
		ST_RS_WR,
		ST_TK_CHECK,
		ST_ROT_LOAD,
		ST_ROT_WALK
	} state_t;

	// same bit packing as the cycle range registers
	typedef struct packed {
		logic               fwd;
		logic [DELAY_W-1:0] delay;
		logic [IDX_W-1:0]   last;
		logic [IDX_W-1:0]   first;
	} cycle_cfg_t;

	typedef struct packed {
		logic [CYC_W-1:0]   active;
		cycle_cfg_t         rng;
		logic [DELAY_W-1:0] count;
	} range_view_t;

	typedef struct packed {
		logic               en;
		logic [DELAY_W-1:0] value;
	} ctr_upd_t;

	typedef logic [2**IDX_W-1:0][IDX_W-1:0] wrap_tbl_t;

	// index modulo n for every 8-bit index, built by counting
	function automatic wrap_tbl_t make_wrap_tbl(int unsigned n);
		wrap_tbl_t        t;
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < 2**IDX_W; i++) begin
			t[i] = r;
			if (int'(r) == int'(n) - 1) begin
				r = '0;
			end else begin
				r = r + 1'b1;
			end
		end
		return t;
	endfunction

endpackage
`default_nettype wire

/* hdl/pcc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_ram
// Simple dual-port palette memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcc_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* hdl/pcc_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_cfg
// Register file of the cycle ranges and their delay counters.
// ----------------------------------------------------------------------------
module pcc_cfg #(
	parameter int unsigned MAX_CYCLES = pcc_pkg::MAX_CYCLES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [pcc_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [pcc_pkg::REG_DATA_W-1:0]   wr_data,
	input  wire logic [pcc_pkg::CYC_W-1:0]        sel,
	input  wire pcc_pkg::ctr_upd_t                upd,
	output pcc_pkg::range_view_t                  view
);

	import pcc_pkg::*;

	cycle_cfg_t         rng_q [MAX_CYCLES];
	logic [DELAY_W-1:0] ctr_q [MAX_CYCLES];
	logic [CYC_W-1:0]   in_use_q;
	cycle_cfg_t         wr_cfg;

	assign wr_cfg = cycle_cfg_t'(wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < MAX_CYCLES; i++) begin
				rng_q[i] <= '0;
				ctr_q[i] <= '0;
			end
		end else begin
			if (wr_en && wr_index == REG_CYCLES_IN_USE) begin
				in_use_q <= wr_data[CYC_W-1:0];
			end
			for (int i = 0; i < MAX_CYCLES; i++) begin
				if (wr_en && wr_index == REG_CYCLE_0 + REG_IDX_W'(i)) begin
					rng_q[i] <= wr_cfg;
					ctr_q[i] <= wr_cfg.delay;
				end else if (upd.en && sel == CYC_W'(i)) begin
					ctr_q[i] <= upd.value;
				end
			end
		end
	end

	always_comb begin
		view.active = (in_use_q > CYC_W'(MAX_CYCLES)) ? CYC_W'(MAX_CYCLES) : in_use_q;
		view.rng    = '0;
		view.count  = '0;
		for (int i = 0; i < MAX_CYCLES; i++) begin
			if (sel == CYC_W'(i)) begin
				view.rng   = rng_q[i];
				view.count = ctr_q[i];
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/pcc_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_engine
// Command sequencer: entry write and read, restore sweep, and the tick walk
// that rotates palette ranges by read-modify-write through the memory.
// ----------------------------------------------------------------------------
module pcc_engine #(
	parameter int unsigned PALETTE_ENTRIES = pcc_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [pcc_pkg::MODE_W-1:0]           mode,
	input  wire logic [pcc_pkg::IDX_W-1:0]            entry_index,
	input  wire logic [pcc_pkg::COLOR_W-1:0]          entry_color,
	output logic                                      done,
	output logic [pcc_pkg::COLOR_W-1:0]               read_color,
	output logic [pcc_pkg::MASK_W-1:0]                rotated_mask,
	output logic [pcc_pkg::CYC_W-1:0]                 sel,
	input  wire pcc_pkg::range_view_t                 view,
	output pcc_pkg::ctr_upd_t                         upd,
	output logic                                      cur_we,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]        cur_waddr,
	output logic [pcc_pkg::COLOR_W-1:0]               cur_wdata,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]        cur_raddr,
	input  wire logic [pcc_pkg::COLOR_W-1:0]          cur_rdata,
	output logic                                      base_we,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]        base_waddr,
	output logic [$clog2(PALETTE_ENTRIES)-1:0]        base_raddr,
	input  wire logic [pcc_pkg::COLOR_W-1:0]          base_rdata
);

	import pcc_pkg::*;

	localparam int unsigned IW      = $clog2(PALETTE_ENTRIES);
	localparam wrap_tbl_t   WrapTbl = make_wrap_tbl(PALETTE_ENTRIES);
	localparam logic [IW:0] LenOne  = {{IW{1'b0}}, 1'b1};
	localparam logic [IW-1:0] LastEntry = IW'(PALETTE_ENTRIES - 1);

	state_t             state_q, state_d;
	logic [IW-1:0]      addr_q;
	logic [IW:0]        cnt_q;
	logic               fwd_q;
	logic [COLOR_W-1:0] carry_q;
	logic [CYC_W-1:0]   cyc_q;
	logic [MASK_W-1:0]  mask_q;
	logic               done_q;
	logic [COLOR_W-1:0] read_color_q;
	logic [MASK_W-1:0]  rotated_mask_q;

	logic               accept;
	logic               finish;
	mode_t              mode_in;
	logic [IW-1:0]      in_idx;
	logic [IW-1:0]      rng_first, rng_last;
	logic [IW-1:0]      walk_start, walk_first_rd, walk_next;
	logic [IW:0]        walk_len;
	logic               tk_end, tk_rot, walk_last, rs_last;

	assign mode_in       = mode_t'(mode);
	assign accept        = start && (state_q == ST_IDLE);
	assign finish        = (state_q != ST_IDLE) && (state_d == ST_IDLE);
	assign in_idx        = WrapTbl[entry_index][IW-1:0];
	assign rng_first     = WrapTbl[view.rng.first][IW-1:0];
	assign rng_last      = WrapTbl[view.rng.last][IW-1:0];
	assign walk_start    = view.rng.fwd ? rng_first : rng_last;
	assign walk_first_rd = view.rng.fwd ? rng_last : rng_first;
	assign walk_len      = (rng_first <= rng_last)
		? ({1'b0, rng_last} - {1'b0, rng_first} + LenOne) : LenOne;
	assign walk_next     = fwd_q ? addr_q + 1'b1 : addr_q - 1'b1;
	assign walk_last     = (cnt_q == LenOne);
	assign rs_last       = (addr_q == LastEntry);
	assign tk_end        = (cyc_q >= view.active);
	assign tk_rot        = (view.count <= DELAY_W'(1));
	assign sel           = cyc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (mode_in)
						MODE_TICK:    state_d = ST_TK_CHECK;
						MODE_WRITE:   state_d = ST_IDLE;
						MODE_READ:    state_d = ST_RD_WAIT;
						MODE_RESTORE: state_d = ST_RS_RD;
					endcase
				end
			end
			ST_RD_WAIT:  state_d = ST_IDLE;
			ST_RS_RD:    state_d = ST_RS_WR;
			ST_RS_WR:    state_d = rs_last ? ST_IDLE : ST_RS_RD;
			ST_TK_CHECK: begin
				if (tk_end) begin
					state_d = ST_IDLE;
				end else if (tk_rot) begin
					state_d = ST_ROT_LOAD;
				end
			end
			ST_ROT_LOAD: state_d = ST_ROT_WALK;
			ST_ROT_WALK: state_d = walk_last ? ST_TK_CHECK : ST_ROT_WALK;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory and counter controls
	always_comb begin
		cur_we     = 1'b0;
		cur_waddr  = addr_q;
		cur_wdata  = carry_q;
		cur_raddr  = addr_q;
		base_we    = 1'b0;
		base_waddr = in_idx;
		base_raddr = addr_q;
		upd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && mode_in == MODE_WRITE) begin
					cur_we    = 1'b1;
					base_we   = 1'b1;
					cur_waddr = in_idx;
					cur_wdata = entry_color;
				end else if (start && mode_in == MODE_READ) begin
					cur_raddr = in_idx;
				end
			end
			ST_RS_WR: begin
				cur_we    = 1'b1;
				cur_wdata = base_rdata;
			end
			ST_TK_CHECK: begin
				if (!tk_end) begin
					upd.en    = 1'b1;
					upd.value = tk_rot ? view.rng.delay : view.count - 1'b1;
					if (tk_rot) begin
						cur_raddr = walk_first_rd;
					end
				end
			end
			ST_ROT_WALK: begin
				cur_we    = 1'b1;
				cur_raddr = walk_next;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && mode_in == MODE_WRITE) || finish;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= '0;
			cyc_q  <= '0;
			mask_q <= '0;
		end
		if (accept || finish) begin
			read_color_q   <= (state_q == ST_RD_WAIT) ? cur_rdata : '0;
			rotated_mask_q <= (state_q == ST_TK_CHECK) ? mask_q : '0;
		end
		case (state_q)
			ST_RS_WR: addr_q <= addr_q + 1'b1;
			ST_TK_CHECK: begin
				if (!tk_end) begin
					if (tk_rot) begin
						addr_q        <= walk_start;
						cnt_q         <= walk_len;
						fwd_q         <= view.rng.fwd;
						mask_q[cyc_q] <= 1'b1;
					end else begin
						cyc_q <= cyc_q + 1'b1;
					end
				end
			end
			ST_ROT_LOAD: carry_q <= cur_rdata;
			ST_ROT_WALK: begin
				carry_q <= cur_rdata;
				if (walk_last) begin
					cyc_q <= cyc_q + 1'b1;
				end else begin
					cnt_q  <= cnt_q - 1'b1;
					addr_q <= walk_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign read_color   = read_color_q;
	assign rotated_mask = rotated_mask_q;

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command finished without a result strobe");

	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT_WALK |-> cnt_q != '0)
		else $error("rotation walk with empty length");

	a_walk_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT_WALK && !walk_last) |-> cur_raddr != cur_waddr)
		else $error("rotation reads the entry it writes");

	a_cyc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT_LOAD || state_q == ST_ROT_WALK) |-> cyc_q < view.active)
		else $error("rotating an inactive range");

endmodule
`default_nettype wire

/* hdl/palette_color_cycler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// palette_color_cycler
// Palette color cycling with a base and a current palette in memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result word
// appears on read_color and rotated_mask with done high for a single cycle and
// cannot be held off. A new command may start in the cycle done is shown.
// A write completes without leaving idle; a read waits on the registered read
// port; restore copies the base palette, one entry per read and write pair on
// the palette memories. A tick checks each active range in turn: its counter
// only counts down, or it is reloaded and the range rotates, writing L entries
// through the single write port of the current palette, L being end - start + 1
// (1 when start is above end).
// ----------------------------------------------------------------------------
module palette_color_cycler #(
	parameter int unsigned MAX_CYCLES      = pcc_pkg::MAX_CYCLES_DEF,
	parameter int unsigned PALETTE_ENTRIES = pcc_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [pcc_pkg::MODE_W-1:0]       mode,
	input  wire logic [pcc_pkg::IDX_W-1:0]        entry_index,
	input  wire logic [pcc_pkg::COLOR_W-1:0]      entry_color,
	output logic                                  done,
	output logic [pcc_pkg::COLOR_W-1:0]           read_color,
	output logic [pcc_pkg::MASK_W-1:0]            rotated_mask,
	input  wire logic                             wr_en,
	input  wire logic [pcc_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [pcc_pkg::REG_DATA_W-1:0]   wr_data
);

	import pcc_pkg::*;

	localparam int unsigned IW = $clog2(PALETTE_ENTRIES);

	logic [CYC_W-1:0]   sel;
	range_view_t        view;
	ctr_upd_t           upd;
	logic               cur_we, base_we;
	logic [IW-1:0]      cur_waddr, cur_raddr, base_waddr, base_raddr;
	logic [COLOR_W-1:0] cur_wdata, cur_rdata, base_rdata;

	pcc_cfg #(
		.MAX_CYCLES (MAX_CYCLES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.sel      (sel),
		.upd      (upd),
		.view     (view)
	);

	pcc_ram #(
		.DEPTH (PALETTE_ENTRIES),
		.WIDTH (COLOR_W)
	) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.raddr (cur_raddr),
		.rdata (cur_rdata)
	);

	pcc_ram #(
		.DEPTH (PALETTE_ENTRIES),
		.WIDTH (COLOR_W)
	) u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (base_waddr),
		.wdata (entry_color),
		.raddr (base_raddr),
		.rdata (base_rdata)
	);

	pcc_engine #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.entry_index  (entry_index),
		.entry_color  (entry_color),
		.done         (done),
		.read_color   (read_color),
		.rotated_mask (rotated_mask),
		.sel          (sel),
		.view         (view),
		.upd          (upd),
		.cur_we       (cur_we),
		.cur_waddr    (cur_waddr),
		.cur_wdata    (cur_wdata),
		.cur_raddr    (cur_raddr),
		.cur_rdata    (cur_rdata),
		.base_we      (base_we),
		.base_waddr   (base_waddr),
		.base_raddr   (base_raddr),
		.base_rdata   (base_rdata)
	);

endmodule
`default_nettype wire
